// ===== design/matrix_power_mod_2x2_assert.svh =====
// assertion macros for the 2x2 modular matrix power block
`ifndef MATRIX_POWER_MOD_2X2_ASSERT_SVH
`define MATRIX_POWER_MOD_2X2_ASSERT_SVH

// same-cycle implication
`define MPM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mpm_pkg.sv =====
// types, constants and microcode program of the 2x2 modular matrix power block
package mpm_pkg;

    localparam int FIELD_W     = 62;
    localparam int EXP_W       = 31;
    localparam int EXP_LSB     = 4 * FIELD_W;
    localparam int MOD_LSB     = EXP_LSB + EXP_W;
    localparam int IN_TDATA_W  = ((MOD_LSB + FIELD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((4 * FIELD_W + 7) / 8) * 8;

    localparam int PC_W     = 6;
    localparam int RA_W     = 4;
    localparam int RF_DEPTH = 12;

    typedef logic [PC_W-1:0] pc_t;
    typedef logic [RA_W-1:0] ra_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_RED,
        OP_CONST,
        OP_MUL,
        OP_MAC,
        OP_MOV,
        OP_SHR,
        OP_OUT,
        OP_PUSH
    } op_t;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_BIT0_CLR,
        C_EXP_ZERO,
        C_MOD_SMALL
    } cond_t;

    typedef enum logic [1:0] {
        UOP_MUL,
        UOP_MAC,
        UOP_RED
    } uop_t;

    typedef struct packed {
        logic start;
        uop_t uop;
    } ucmd_t;

    typedef struct packed {
        op_t        op;
        cond_t      cond;
        ra_t        src_a;
        ra_t        src_b;
        ra_t        dst;
        logic [1:0] fld;
        logic       imm;
        pc_t        target;
    } ctl_t;

    // register file map: accumulator, base, scratch
    localparam ra_t R_A0 = 4'd0;
    localparam ra_t R_A1 = 4'd1;
    localparam ra_t R_A2 = 4'd2;
    localparam ra_t R_A3 = 4'd3;
    localparam ra_t R_B0 = 4'd4;
    localparam ra_t R_B1 = 4'd5;
    localparam ra_t R_B2 = 4'd6;
    localparam ra_t R_B3 = 4'd7;
    localparam ra_t R_T0 = 4'd8;
    localparam ra_t R_T1 = 4'd9;
    localparam ra_t R_T2 = 4'd10;
    localparam ra_t R_T3 = 4'd11;

    localparam logic [1:0] F0 = 2'd0;
    localparam logic [1:0] F1 = 2'd1;
    localparam logic [1:0] F2 = 2'd2;
    localparam logic [1:0] F3 = 2'd3;

    localparam pc_t L_LOOP  = 6'd9;
    localparam pc_t L_SHIFT = 6'd22;
    localparam pc_t L_OUT   = 6'd37;
    localparam pc_t L_NONE  = 6'd0;

    function automatic ctl_t mk(input op_t op, input cond_t cond, input ra_t a,
                                input ra_t b, input ra_t d, input logic [1:0] f,
                                input logic imm, input pc_t tgt);
        ctl_t c;
        c.op     = op;
        c.cond   = cond;
        c.src_a  = a;
        c.src_b  = b;
        c.dst    = d;
        c.fld    = f;
        c.imm    = imm;
        c.target = tgt;
        return c;
    endfunction

    function automatic ctl_t mpm_prog(input pc_t pc);
        ctl_t c;
        case (pc)
            // bail out on a modulus below two
            6'd0:  c = mk(OP_NOP,   C_MOD_SMALL, R_A0, R_A0, R_A0, F0, 1'b0, L_OUT);
            // reduce base entries
            6'd1:  c = mk(OP_RED,   C_NONE, R_A0, R_A0, R_B0, F0, 1'b0, L_NONE);
            6'd2:  c = mk(OP_RED,   C_NONE, R_A0, R_A0, R_B1, F1, 1'b0, L_NONE);
            6'd3:  c = mk(OP_RED,   C_NONE, R_A0, R_A0, R_B2, F2, 1'b0, L_NONE);
            6'd4:  c = mk(OP_RED,   C_NONE, R_A0, R_A0, R_B3, F3, 1'b0, L_NONE);
            // accumulator starts as identity
            6'd5:  c = mk(OP_CONST, C_NONE, R_A0, R_A0, R_A0, F0, 1'b1, L_NONE);
            6'd6:  c = mk(OP_CONST, C_NONE, R_A0, R_A0, R_A1, F0, 1'b0, L_NONE);
            6'd7:  c = mk(OP_CONST, C_NONE, R_A0, R_A0, R_A2, F0, 1'b0, L_NONE);
            6'd8:  c = mk(OP_CONST, C_NONE, R_A0, R_A0, R_A3, F0, 1'b1, L_NONE);
            // acc = acc * base when the low exponent bit is set
            6'd9:  c = mk(OP_NOP,   C_BIT0_CLR, R_A0, R_A0, R_A0, F0, 1'b0, L_SHIFT);
            6'd10: c = mk(OP_MUL,   C_NONE, R_A0, R_B0, R_A0, F0, 1'b0, L_NONE);
            6'd11: c = mk(OP_MAC,   C_NONE, R_A1, R_B2, R_T0, F0, 1'b0, L_NONE);
            6'd12: c = mk(OP_MUL,   C_NONE, R_A0, R_B1, R_A0, F0, 1'b0, L_NONE);
            6'd13: c = mk(OP_MAC,   C_NONE, R_A1, R_B3, R_T1, F0, 1'b0, L_NONE);
            6'd14: c = mk(OP_MUL,   C_NONE, R_A2, R_B0, R_A0, F0, 1'b0, L_NONE);
            6'd15: c = mk(OP_MAC,   C_NONE, R_A3, R_B2, R_T2, F0, 1'b0, L_NONE);
            6'd16: c = mk(OP_MUL,   C_NONE, R_A2, R_B1, R_A0, F0, 1'b0, L_NONE);
            6'd17: c = mk(OP_MAC,   C_NONE, R_A3, R_B3, R_T3, F0, 1'b0, L_NONE);
            6'd18: c = mk(OP_MOV,   C_NONE, R_T0, R_A0, R_A0, F0, 1'b0, L_NONE);
            6'd19: c = mk(OP_MOV,   C_NONE, R_T1, R_A0, R_A1, F0, 1'b0, L_NONE);
            6'd20: c = mk(OP_MOV,   C_NONE, R_T2, R_A0, R_A2, F0, 1'b0, L_NONE);
            6'd21: c = mk(OP_MOV,   C_NONE, R_T3, R_A0, R_A3, F0, 1'b0, L_NONE);
            // next exponent bit, stop when none left
            6'd22: c = mk(OP_SHR,   C_NONE, R_A0, R_A0, R_A0, F0, 1'b0, L_NONE);
            6'd23: c = mk(OP_NOP,   C_EXP_ZERO, R_A0, R_A0, R_A0, F0, 1'b0, L_OUT);
            // base = base * base
            6'd24: c = mk(OP_MUL,   C_NONE, R_B0, R_B0, R_A0, F0, 1'b0, L_NONE);
            6'd25: c = mk(OP_MAC,   C_NONE, R_B1, R_B2, R_T0, F0, 1'b0, L_NONE);
            6'd26: c = mk(OP_MUL,   C_NONE, R_B0, R_B1, R_A0, F0, 1'b0, L_NONE);
            6'd27: c = mk(OP_MAC,   C_NONE, R_B1, R_B3, R_T1, F0, 1'b0, L_NONE);
            6'd28: c = mk(OP_MUL,   C_NONE, R_B2, R_B0, R_A0, F0, 1'b0, L_NONE);
            6'd29: c = mk(OP_MAC,   C_NONE, R_B3, R_B2, R_T2, F0, 1'b0, L_NONE);
            6'd30: c = mk(OP_MUL,   C_NONE, R_B2, R_B1, R_A0, F0, 1'b0, L_NONE);
            6'd31: c = mk(OP_MAC,   C_NONE, R_B3, R_B3, R_T3, F0, 1'b0, L_NONE);
            6'd32: c = mk(OP_MOV,   C_NONE, R_T0, R_A0, R_B0, F0, 1'b0, L_NONE);
            6'd33: c = mk(OP_MOV,   C_NONE, R_T1, R_A0, R_B1, F0, 1'b0, L_NONE);
            6'd34: c = mk(OP_MOV,   C_NONE, R_T2, R_A0, R_B2, F0, 1'b0, L_NONE);
            6'd35: c = mk(OP_MOV,   C_NONE, R_T3, R_A0, R_B3, F0, 1'b0, L_NONE);
            6'd36: c = mk(OP_NOP,   C_ALWAYS, R_A0, R_A0, R_A0, F0, 1'b0, L_LOOP);
            // move accumulator to the output register
            6'd37: c = mk(OP_OUT,   C_NONE, R_A0, R_A0, R_A0, F0, 1'b0, L_NONE);
            6'd38: c = mk(OP_OUT,   C_NONE, R_A1, R_A0, R_A0, F1, 1'b0, L_NONE);
            6'd39: c = mk(OP_OUT,   C_NONE, R_A2, R_A0, R_A0, F2, 1'b0, L_NONE);
            6'd40: c = mk(OP_OUT,   C_NONE, R_A3, R_A0, R_A0, F3, 1'b0, L_NONE);
            default: c = mk(OP_PUSH, C_NONE, R_A0, R_A0, R_A0, F0, 1'b0, L_NONE);
        endcase
        return c;
    endfunction

endpackage

// ===== design/mpm_mulmod.sv =====
// shift-and-add modular multiply and bit-serial reduction unit
module mpm_mulmod #(
    parameter int MOD_BITS = 62
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mpm_pkg::ucmd_t        cmd,
    input  logic [MOD_BITS-1:0]   op_a,
    input  logic [MOD_BITS-1:0]   op_b,
    input  logic [MOD_BITS-1:0]   modulus,
    output logic                  busy,
    output logic [MOD_BITS-1:0]   result
);
    import mpm_pkg::*;

    localparam int CNT_W = $clog2(MOD_BITS + 1);

    logic [MOD_BITS-1:0] a_reg;
    logic [MOD_BITS-1:0] b_reg;
    logic [MOD_BITS-1:0] s_reg;
    logic [CNT_W-1:0]    cnt_reg;
    uop_t                uop_reg;
    logic                busy_reg;

    logic [MOD_BITS:0] m_ext;
    logic [MOD_BITS:0] a_dbl;
    logic [MOD_BITS:0] a_red;
    logic [MOD_BITS:0] s_sum;
    logic [MOD_BITS:0] s_red;

    always_comb
    begin
        m_ext = {1'b0, modulus};
        a_dbl = {a_reg, 1'b0};
        a_red = (a_dbl >= m_ext) ? (a_dbl - m_ext) : a_dbl;
        if (uop_reg == UOP_RED)
        begin
            s_sum = {s_reg, b_reg[MOD_BITS-1]};
        end
        else
        begin
            s_sum = {1'b0, s_reg} + {1'b0, a_reg};
        end
        s_red = (s_sum >= m_ext) ? (s_sum - m_ext) : s_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (uop_reg == UOP_RED)
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
            else if (b_reg[MOD_BITS-1:1] == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            uop_reg <= cmd.uop;
            cnt_reg <= CNT_W'(MOD_BITS);
            if (cmd.uop != UOP_MAC)
            begin
                s_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (uop_reg == UOP_RED)
            begin
                s_reg   <= s_red[MOD_BITS-1:0];
                b_reg   <= b_reg << 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            else
            begin
                if (b_reg[0])
                begin
                    s_reg <= s_red[MOD_BITS-1:0];
                end
                a_reg <= a_red[MOD_BITS-1:0];
                b_reg <= b_reg >> 1;
            end
        end
    end

    assign busy   = busy_reg;
    assign result = s_reg;

endmodule

// ===== design/matrix_power_mod_2x2.sv =====
// up to 16 multiply operations per exponent bit, through one shared shift-add multiply unit
// throughput: one item at a time; the next beat is taken as soon as the sequencer is idle
// reset: asynchronous, clears sequencer state and output valid; register file is not cleared
// top level of the microcoded 2x2 modular matrix power block
`include "matrix_power_mod_2x2_assert.svh"

module matrix_power_mod_2x2 #(
    parameter int MOD_BITS = 62,
    parameter int EXP_BITS = 31
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // in_00, in_01, in_10, in_11, exponent, modulus
    input  logic [mpm_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_00, out_01, out_10, out_11
    output logic [mpm_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import mpm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_EXEC = 4'b0100,
        ST_WAIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    pc_t    pc_reg, pc_next;

    logic [MOD_BITS-1:0] in_reg [4];
    logic [MOD_BITS-1:0] mod_reg;
    logic [EXP_BITS-1:0] exp_reg;
    logic                small_reg;
    logic [MOD_BITS-1:0] rd_a_reg;
    logic [MOD_BITS-1:0] rd_b_reg;
    logic [MOD_BITS-1:0] rf_mem [RF_DEPTH];
    logic [FIELD_W-1:0]  out_data_reg [4];
    logic                out_valid_reg;

    ctl_t                ctl;
    ucmd_t               ucmd;
    logic                unit_op;
    logic                unit_busy;
    logic [MOD_BITS-1:0] unit_result;
    logic [MOD_BITS-1:0] unit_b;
    logic                cond_hit;
    logic                rf_we;
    logic [MOD_BITS-1:0] rf_wdata;
    logic                in_fire;
    logic                out_fire;
    logic                push;

    assign ctl      = mpm_prog(pc_reg);
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign unit_op  = (ctl.op == OP_MUL) || (ctl.op == OP_MAC) || (ctl.op == OP_RED);
    assign push     = (state_reg == ST_EXEC) && (ctl.op == OP_PUSH);

    always_comb
    begin
        unique case (ctl.cond)
            C_NONE:      cond_hit = 1'b0;
            C_ALWAYS:    cond_hit = 1'b1;
            C_BIT0_CLR:  cond_hit = !exp_reg[0];
            C_EXP_ZERO:  cond_hit = (exp_reg == '0);
            C_MOD_SMALL: cond_hit = small_reg;
            default:     cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        ucmd.start = (state_reg == ST_EXEC) && unit_op;
        unique case (ctl.op)
            OP_MAC:  ucmd.uop = UOP_MAC;
            OP_RED:  ucmd.uop = UOP_RED;
            default: ucmd.uop = UOP_MUL;
        endcase
        unit_b = (ctl.op == OP_RED) ? in_reg[ctl.fld] : rd_b_reg;
    end

    mpm_mulmod #(
        .MOD_BITS (MOD_BITS)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ucmd),
        .op_a    (rd_a_reg),
        .op_b    (unit_b),
        .modulus (mod_reg),
        .busy    (unit_busy),
        .result  (unit_result)
    );

    always_comb
    begin
        rf_we = ((state_reg == ST_EXEC) && ((ctl.op == OP_CONST) || (ctl.op == OP_MOV)))
             || ((state_reg == ST_WAIT) && !unit_busy
                 && ((ctl.op == OP_RED) || (ctl.op == OP_MAC)));
        unique case (ctl.op)
            OP_CONST: rf_wdata = MOD_BITS'(ctl.imm);
            OP_MOV:   rf_wdata = rd_a_reg;
            default:  rf_wdata = unit_result;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_READ;
                    pc_next    = '0;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (unit_op)
                begin
                    state_next = ST_WAIT;
                end
                else if (ctl.op == OP_PUSH)
                begin
                    state_next = ST_IDLE;
                end
                else if (!((ctl.op == OP_OUT) && out_valid_reg))
                begin
                    state_next = ST_READ;
                    pc_next    = cond_hit ? ctl.target : pc_t'(pc_reg + 1'b1);
                end
            end
            ST_WAIT:
            begin
                if (!unit_busy)
                begin
                    state_next = ST_READ;
                    pc_next    = cond_hit ? ctl.target : pc_t'(pc_reg + 1'b1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int k = 0; k < 4; k++)
            begin
                in_reg[k] <= s_tdata[k*FIELD_W +: MOD_BITS];
            end
            mod_reg   <= s_tdata[MOD_LSB +: MOD_BITS];
            exp_reg   <= s_tdata[EXP_LSB +: EXP_BITS];
            small_reg <= (s_tdata[MOD_LSB+1 +: MOD_BITS-1] == '0);
        end
        else if ((state_reg == ST_EXEC) && (ctl.op == OP_SHR))
        begin
            exp_reg <= exp_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= rf_mem[ctl.src_a];
        rd_b_reg <= rf_mem[ctl.src_b];
        if (rf_we)
        begin
            rf_mem[ctl.dst] <= rf_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_EXEC) && (ctl.op == OP_OUT) && !out_valid_reg)
        begin
            out_data_reg[ctl.fld] <= small_reg ? '0 : FIELD_W'(rd_a_reg);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg[3], out_data_reg[2], out_data_reg[1], out_data_reg[0]};

    `MPM_ASSERT_IMP(a_start_free, ucmd.start, !unit_busy, "unit started while busy")
    `MPM_ASSERT_IMP(a_push_free, push, !out_valid_reg, "result pushed over a pending beat")
    `MPM_ASSERT_IMP(a_done_wait, $fell(unit_busy), state_reg == ST_WAIT, "unit done off wait")
    `MPM_ASSERT_NXT(a_push_next, push, m_tvalid && s_tready, "push did not present a result")

endmodule
